/* design/tks_pkg.sv */
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants for the ranked score table
// Score width, clamp limit, command codes and the default table depth.
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int SCORE_W       = 7;
    localparam int VALUE_W       = 16;
    localparam int INDEX_W       = 8;
    localparam int CMD_W         = 2;
    localparam int ENTRIES_DEF   = 10;

    typedef logic [SCORE_W-1:0] t_score;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [CMD_W-1:0]   t_cmd;

    localparam t_score SCORE_MAX  = t_score'(99);
    localparam t_score SCORE_ZERO = '0;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_LOAD   = 2'd1;
    localparam t_cmd CMD_READ   = 2'd2;
    localparam t_cmd CMD_CLEAR  = 2'd3;

endpackage

/* design/top_k_score_table.sv */
// ----------------------------------------------------------------------------
// top_k_score_table: ranked table of the best scores
// Keeps a descending list of clamped scores; insert, load, read and clear.
// ----------------------------------------------------------------------------
// Result: an accepted request is taken into the request register, then its
//   result into the output register (o_valid high for that one cycle).
// Throughput: one request per cycle while o_busy is low; the insertion network
//   compares all entries in parallel, so the table update fits in a single stage.
// Reset: synchronous, active low; clears the table to zero and holds o_busy
//   high through reset and the first edge after release, so no request is
//   taken at that edge. The receiver cannot stall.
// ----------------------------------------------------------------------------
module top_k_score_table #(
    parameter int TABLE_ENTRIES = tks_pkg::ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  tks_pkg::t_cmd   i_command,
    input  tks_pkg::t_value i_score_value,
    input  tks_pkg::t_index i_read_index,
    output logic            o_valid,
    output tks_pkg::t_score o_read_score,
    output logic            o_table_changed
);
    import tks_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // ---------------- stage 1: request register ----------------
    logic   r_busy;
    logic   r_req_vld;
    t_cmd   r_cmd;
    t_score r_score;     // already clamped per command
    t_index r_idx;

    logic   accept;
    t_score n_score;

    assign accept = i_start && !r_busy;
    assign o_busy = r_busy;

    // insert saturates at the limit; load treats anything out of range as 0
    always_comb begin
        if (i_score_value > t_value'(SCORE_MAX)) begin
            n_score = (i_command == CMD_INSERT) ? SCORE_MAX : SCORE_ZERO;
        end else begin
            n_score = i_score_value[SCORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_req_vld <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r_req_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_command;
            r_score <= n_score;
            r_idx   <= i_read_index;
        end
    end

    // ---------------- stage 2: table update and result ----------------
    t_score r_table [TABLE_ENTRIES];
    t_score ins_table [TABLE_ENTRIES];
    logic   ins_placed;

    tks_insert #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_insert (
        .i_table  (r_table),
        .i_score  (r_score),
        .o_table  (ins_table),
        .o_placed (ins_placed)
    );

    logic   r_out_vld;
    t_score r_out_score;
    logic   r_out_changed;
    t_score n_out_score;
    logic   n_out_changed;

    always_comb begin
        n_out_score   = SCORE_ZERO;
        n_out_changed = 1'b0;
        unique case (r_cmd)
            CMD_INSERT: n_out_changed = ins_placed;
            CMD_LOAD:   n_out_changed = 1'b0;    // load never flags
            CMD_READ: begin
                if (r_idx < t_index'(TABLE_ENTRIES)) begin
                    n_out_score = r_table[r_idx[IDX_W-1:0]];
                end
            end
            CMD_CLEAR:  n_out_changed = 1'b1;    // flags even on an empty table
            default:    n_out_changed = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_table[i] <= SCORE_ZERO;
            end
        end else if (r_req_vld) begin
            if (r_cmd == CMD_INSERT || r_cmd == CMD_LOAD) begin
                r_table <= ins_table;
            end else if (r_cmd == CMD_CLEAR) begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    r_table[i] <= SCORE_ZERO;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_vld) begin
            r_out_score   <= n_out_score;
            r_out_changed <= n_out_changed;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_read_score    = r_out_score;
    assign o_table_changed = r_out_changed;

endmodule

/* design/tks_insert.sv */
// ----------------------------------------------------------------------------
// tks_insert: sorted insertion network
// Every entry compares against the new score at once; entries at and below
// the first smaller one shift down by one place.
// ----------------------------------------------------------------------------
module tks_insert #(
    parameter int TABLE_ENTRIES = tks_pkg::ENTRIES_DEF
) (
    input  tks_pkg::t_score i_table [TABLE_ENTRIES],
    input  tks_pkg::t_score i_score,
    output tks_pkg::t_score o_table [TABLE_ENTRIES],
    output logic            o_placed
);
    import tks_pkg::*;

    logic [TABLE_ENTRIES-1:0] greater;

    // table is kept descending, so greater is a thermometer code:
    // once set at some entry it stays set for all entries below
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            greater[i] = i_score > i_table[i];
        end
    end

    always_comb begin
        o_table[0] = greater[0] ? i_score : i_table[0];
        for (int i = 1; i < TABLE_ENTRIES; i++) begin
            if (!greater[i]) begin
                o_table[i] = i_table[i];
            end else if (greater[i-1]) begin
                o_table[i] = i_table[i-1];
            end else begin
                o_table[i] = i_score;
            end
        end
    end

    assign o_placed = |greater;

endmodule

/* design/tks_checker.sv */
// ----------------------------------------------------------------------------
// tks_checker: port-level checks for the ranked score table
// Result timing against accepted requests, the flag rules per command and the score limit.
// ----------------------------------------------------------------------------
module tks_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_start,
    input logic            o_busy,
    input tks_pkg::t_cmd   i_command,
    input logic            o_valid,
    input tks_pkg::t_score o_read_score,
    input logic            o_table_changed
);
    import tks_pkg::*;

    logic accept;
    assign accept = i_start && !o_busy;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_valid)
        else $error("accepted request produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 2))
        else $error("result without a request");

    a_clear_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_CLEAR) |-> ##2 (o_table_changed
            && o_read_score == SCORE_ZERO))
        else $error("clear result wrong");

    a_read_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_command == CMD_READ || i_command == CMD_LOAD))
            |-> ##2 !o_table_changed)
        else $error("read or load raised change flag");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_read_score <= SCORE_MAX))
        else $error("score above limit");

endmodule

bind top_k_score_table tks_checker u_tks_checker (.*);
